// File: hw/rtl/tgu_pkg.sv
// Shared definitions for the triangle tangent block: field widths, sequencing
// constants and the controller-to-datapath command bundle.
// No dependencies.
`timescale 1ns / 1ps

package tgu_pkg;

   // Fixed field widths of the item channels
   localparam int ID_WIDTH   = 16;
   localparam int DATA_WIDTH = 32;

   // Defaults for the top-level parameters
   localparam int DEF_INDEX_BITS = 16;
   localparam int DEF_FRAC_BITS  = 16;

   // Exact products and accumulators: 32 x 32 signed
   localparam int PROD_WIDTH = 2 * DATA_WIDTH;

   // Quotient bits below the saturation point of a signed 32-bit result
   localparam int QUO_BITS = DATA_WIDTH - 1;

   // Multiply schedule: det (2 products) and three numerators (2 each)
   localparam int MUL_STEPS      = 8;
   localparam int MUL_STEP_WIDTH = $clog2(MUL_STEPS);

   // Shared step counter covers the multiply schedule and the divide loop
   localparam int STEP_WIDTH = $clog2(QUO_BITS);

   // Corner position within a face
   localparam logic [1:0] CORNER_FIRST  = 2'd0;
   localparam logic [1:0] CORNER_SECOND = 2'd1;
   localparam logic [1:0] CORNER_LAST   = 2'd2;

   // Saturation bounds of a tangent component
   localparam logic signed [DATA_WIDTH-1:0] TAN_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
   localparam logic signed [DATA_WIDTH-1:0] TAN_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

   typedef struct packed {
      logic                      load_c0;    // capture first corner
      logic                      load_c1;    // capture second corner, form dP1/dUV1
      logic                      load_c2;    // capture third corner, form dP2/dUV2
      logic [MUL_STEP_WIDTH-1:0] mul_step;   // operand pair for the multiplier
      logic                      acc_en;     // fold previous product
      logic [MUL_STEP_WIDTH-1:0] acc_step;   // which product is being folded
      logic                      div_init;   // set up divider lanes
      logic                      div_step;   // one quotient bit per lane
      logic                      div_done;   // latch tangent and face ids
      logic [1:0]                emit_idx;   // corner of the result on offer
   } tgu_cmd_type;

endpackage

// File: hw/rtl/tgu_if.sv
// Handshake channels of the triangle tangent block: corner items in,
// tangent items out. Depends on nothing.
`timescale 1ns / 1ps

interface tgu_req_if;
   logic               valid;
   logic               ready;
   logic [15:0]        vertex_id;
   logic signed [31:0] pos_x;
   logic signed [31:0] pos_y;
   logic signed [31:0] pos_z;
   logic signed [31:0] tex_u;
   logic signed [31:0] tex_v;

   modport source (output valid, vertex_id, pos_x, pos_y, pos_z, tex_u, tex_v,
                   input ready);
   modport sink   (input valid, vertex_id, pos_x, pos_y, pos_z, tex_u, tex_v,
                   output ready);
endinterface

interface tgu_rsp_if;
   logic               valid;
   logic               ready;
   logic [15:0]        out_vertex_id;
   logic signed [31:0] tangent_x;
   logic signed [31:0] tangent_y;
   logic signed [31:0] tangent_z;
   logic               degenerate;
   logic               last_of_face;

   modport source (output valid, out_vertex_id, tangent_x, tangent_y, tangent_z,
                   degenerate, last_of_face, input ready);
   modport sink   (input valid, out_vertex_id, tangent_x, tangent_y, tangent_z,
                   degenerate, last_of_face, output ready);
endinterface

// File: hw/rtl/tgu_ctrl.sv
// Sequencer of the triangle tangent block: corner counting, multiply
// schedule, divide loop and result emission. Uses tgu_pkg.
`timescale 1ns / 1ps

module tgu_ctrl
   import tgu_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output tgu_cmd_type cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_MUL,
      S_DINIT,
      S_DIV,
      S_FIN,
      S_EMIT
   } state_type;

   state_type             state_ff, state_in;
   logic [1:0]            cnt_ff, cnt_in;
   logic [STEP_WIDTH-1:0] step_ff, step_in;
   logic [1:0]            emit_ff, emit_in;
   logic                  req_fire;
   logic                  rsp_fire;

   always_comb begin
      // Corners of the next face may come in while results drain,
      // but the closing corner waits until the result buffer is free.
      req_ready = (state_ff == S_IDLE) ||
                  ((state_ff == S_EMIT) && (cnt_ff != CORNER_LAST));
      rsp_valid = (state_ff == S_EMIT);
      req_fire  = req_valid && req_ready;
      rsp_fire  = rsp_valid && rsp_ready;

      cmd.load_c0  = req_fire && (cnt_ff == CORNER_FIRST);
      cmd.load_c1  = req_fire && (cnt_ff == CORNER_SECOND);
      cmd.load_c2  = req_fire && (cnt_ff == CORNER_LAST);
      cmd.mul_step = step_ff[MUL_STEP_WIDTH-1:0];
      cmd.acc_en   = (state_ff == S_MUL) && (step_ff != '0);
      cmd.acc_step = MUL_STEP_WIDTH'(step_ff - 1'b1);
      cmd.div_init = (state_ff == S_DINIT);
      cmd.div_step = (state_ff == S_DIV);
      cmd.div_done = (state_ff == S_FIN);
      cmd.emit_idx = emit_ff;

      cnt_in   = cnt_ff;
      state_in = state_ff;
      step_in  = step_ff;
      emit_in  = emit_ff;

      if (req_fire) begin
         cnt_in = (cnt_ff == CORNER_LAST) ? CORNER_FIRST : cnt_ff + 1'b1;
      end

      case (state_ff)
         S_IDLE: begin
            if (cmd.load_c2) begin
               state_in = S_MUL;
               step_in  = '0;
            end
         end
         S_MUL: begin
            // the final step folds the last product
            if (step_ff == STEP_WIDTH'(MUL_STEPS)) begin
               state_in = S_DINIT;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         S_DINIT: begin
            state_in = S_DIV;
            step_in  = '0;
         end
         S_DIV: begin
            if (step_ff == STEP_WIDTH'(QUO_BITS - 1)) begin
               state_in = S_FIN;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         S_FIN: begin
            state_in = S_EMIT;
            emit_in  = CORNER_FIRST;
         end
         S_EMIT: begin
            if (rsp_fire) begin
               if (emit_ff == CORNER_LAST) begin
                  state_in = S_IDLE;
               end else begin
                  emit_in = emit_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= CORNER_FIRST;
         step_ff  <= '0;
         emit_ff  <= CORNER_FIRST;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         step_ff  <= step_in;
         emit_ff  <= emit_in;
      end
   end

endmodule

// File: hw/rtl/tgu_datapath.sv
// Datapath of the triangle tangent block: corner capture with saturated
// deltas, shared 32x32 multiplier, three radix-2 divider lanes, result buffer.
// Uses tgu_pkg; driven by tgu_ctrl commands.
`timescale 1ns / 1ps

module tgu_datapath
   import tgu_pkg::*;
#(
   parameter int INDEX_BITS = DEF_INDEX_BITS,
   parameter int FRAC_BITS  = DEF_FRAC_BITS
) (
   input  logic                         clock,
   input  tgu_cmd_type                  cmd,
   input  logic [ID_WIDTH-1:0]          vertex_id,
   input  logic signed [DATA_WIDTH-1:0] pos_x,
   input  logic signed [DATA_WIDTH-1:0] pos_y,
   input  logic signed [DATA_WIDTH-1:0] pos_z,
   input  logic signed [DATA_WIDTH-1:0] tex_u,
   input  logic signed [DATA_WIDTH-1:0] tex_v,
   output logic [ID_WIDTH-1:0]          out_vertex_id,
   output logic signed [DATA_WIDTH-1:0] tangent_x,
   output logic signed [DATA_WIDTH-1:0] tangent_y,
   output logic signed [DATA_WIDTH-1:0] tangent_z,
   output logic                         degenerate,
   output logic                         last_of_face
);

   localparam int KEEP_BITS = (INDEX_BITS < ID_WIDTH) ? INDEX_BITS : ID_WIDTH;
   localparam int DVD_W     = PROD_WIDTH + FRAC_BITS;

   // Symmetric saturation of a 33-bit difference to +/-(2^31-1)
   function automatic logic signed [DATA_WIDTH-1:0] sat_delta(
      input logic signed [DATA_WIDTH-1:0] a,
      input logic signed [DATA_WIDTH-1:0] b
   );
      logic [DATA_WIDTH:0] d;
      d = {a[DATA_WIDTH-1], a} - {b[DATA_WIDTH-1], b};
      if (!d[DATA_WIDTH] && d[DATA_WIDTH-1]) begin
         sat_delta = TAN_MAX;
      end else if (d[DATA_WIDTH] &&
                   (!d[DATA_WIDTH-1] || (d[DATA_WIDTH-2:0] == '0))) begin
         sat_delta = -TAN_MAX;
      end else begin
         sat_delta = d[DATA_WIDTH-1:0];
      end
   endfunction

   // Corner capture
   logic [KEEP_BITS-1:0]          idx_ff   [3];
   logic signed [DATA_WIDTH-1:0]  p0_ff    [3];
   logic signed [DATA_WIDTH-1:0]  u0_ff, v0_ff;
   logic signed [DATA_WIDTH-1:0]  dp1_ff   [3];
   logic signed [DATA_WIDTH-1:0]  dp2_ff   [3];
   logic signed [DATA_WIDTH-1:0]  du1_ff, dv1_ff, du2_ff, dv2_ff;

   // Multiply and accumulate: entry 0 is det, 1..3 the numerators
   logic signed [DATA_WIDTH-1:0]  mul_a, mul_b;
   logic [1:0]                    mul_lane;
   logic signed [PROD_WIDTH-1:0]  prod_ff;
   logic signed [PROD_WIDTH-1:0]  acc_ff   [4];

   // Divider lanes
   logic [PROD_WIDTH-1:0]         md_w;
   logic [PROD_WIDTH-1:0]         md_ff;
   logic                          degen_ff;
   logic [PROD_WIDTH-1:0]         mag_w    [3];
   logic [DVD_W-1:0]              dvd_w    [3];
   logic [PROD_WIDTH-1:0]         rem_ff   [3];
   logic [QUO_BITS-1:0]           low_ff   [3];
   logic [QUO_BITS-1:0]           q_ff     [3];
   logic                          over_ff  [3];
   logic                          neg_ff   [3];
   logic [PROD_WIDTH:0]           rem_sh   [3];
   logic [PROD_WIDTH:0]           diff_w   [3];
   logic signed [DATA_WIDTH-1:0]  tan_w    [3];
   logic [DATA_WIDTH-1:0]         qx_w     [3];

   // Result buffer
   logic [KEEP_BITS-1:0]          out_id_ff [3];
   logic signed [DATA_WIDTH-1:0]  tan_ff    [3];
   logic                          out_degen_ff;

   // Operand schedule: steps 0/1 give det, then dP1*dv2 and dP2*dv1 per axis
   always_comb begin
      mul_lane = cmd.mul_step[MUL_STEP_WIDTH-1:1] - 1'b1;
      if (cmd.mul_step[MUL_STEP_WIDTH-1:1] == '0) begin
         mul_a = cmd.mul_step[0] ? dv1_ff : du1_ff;
         mul_b = cmd.mul_step[0] ? du2_ff : dv2_ff;
      end else begin
         mul_a = cmd.mul_step[0] ? dp2_ff[mul_lane] : dp1_ff[mul_lane];
         mul_b = cmd.mul_step[0] ? dv1_ff : dv2_ff;
      end
   end

   always_comb begin
      md_w = acc_ff[0][PROD_WIDTH-1] ? PROD_WIDTH'(-acc_ff[0]) : PROD_WIDTH'(acc_ff[0]);
      for (int k = 0; k < 3; k++) begin
         mag_w[k]  = acc_ff[k+1][PROD_WIDTH-1] ? PROD_WIDTH'(-acc_ff[k+1])
                                               : PROD_WIDTH'(acc_ff[k+1]);
         dvd_w[k]  = {mag_w[k], {FRAC_BITS{1'b0}}};
         rem_sh[k] = {rem_ff[k], low_ff[k][QUO_BITS-1]};
         diff_w[k] = rem_sh[k] - {1'b0, md_ff};
         qx_w[k]   = {1'b0, q_ff[k]};
         if (degen_ff) begin
            tan_w[k] = '0;
         end else if (over_ff[k]) begin
            tan_w[k] = neg_ff[k] ? TAN_MIN : TAN_MAX;
         end else begin
            tan_w[k] = neg_ff[k] ? -qx_w[k] : qx_w[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_c0) begin
         idx_ff[0] <= vertex_id[KEEP_BITS-1:0];
         p0_ff[0]  <= pos_x;
         p0_ff[1]  <= pos_y;
         p0_ff[2]  <= pos_z;
         u0_ff     <= tex_u;
         v0_ff     <= tex_v;
      end
      if (cmd.load_c1) begin
         idx_ff[1] <= vertex_id[KEEP_BITS-1:0];
         dp1_ff[0] <= sat_delta(pos_x, p0_ff[0]);
         dp1_ff[1] <= sat_delta(pos_y, p0_ff[1]);
         dp1_ff[2] <= sat_delta(pos_z, p0_ff[2]);
         du1_ff    <= sat_delta(tex_u, u0_ff);
         dv1_ff    <= sat_delta(tex_v, v0_ff);
      end
      if (cmd.load_c2) begin
         idx_ff[2] <= vertex_id[KEEP_BITS-1:0];
         dp2_ff[0] <= sat_delta(pos_x, p0_ff[0]);
         dp2_ff[1] <= sat_delta(pos_y, p0_ff[1]);
         dp2_ff[2] <= sat_delta(pos_z, p0_ff[2]);
         du2_ff    <= sat_delta(tex_u, u0_ff);
         dv2_ff    <= sat_delta(tex_v, v0_ff);
      end

      prod_ff <= mul_a * mul_b;

      // even step opens a sum, odd step subtracts its partner
      if (cmd.acc_en) begin
         if (!cmd.acc_step[0]) begin
            acc_ff[cmd.acc_step[MUL_STEP_WIDTH-1:1]] <= prod_ff;
         end else begin
            acc_ff[cmd.acc_step[MUL_STEP_WIDTH-1:1]] <=
               acc_ff[cmd.acc_step[MUL_STEP_WIDTH-1:1]] - prod_ff;
         end
      end

      if (cmd.div_init) begin
         md_ff    <= md_w;
         degen_ff <= (acc_ff[0] == '0);
         for (int k = 0; k < 3; k++) begin
            // quotient reaches 2^31 exactly when the upper dividend part >= |det|
            rem_ff[k]  <= PROD_WIDTH'(dvd_w[k][DVD_W-1:QUO_BITS]);
            over_ff[k] <= (PROD_WIDTH'(dvd_w[k][DVD_W-1:QUO_BITS]) >= md_w);
            low_ff[k]  <= dvd_w[k][QUO_BITS-1:0];
            neg_ff[k]  <= acc_ff[k+1][PROD_WIDTH-1] ^ acc_ff[0][PROD_WIDTH-1];
         end
      end

      if (cmd.div_step) begin
         for (int k = 0; k < 3; k++) begin
            rem_ff[k] <= diff_w[k][PROD_WIDTH] ? rem_sh[k][PROD_WIDTH-1:0]
                                               : diff_w[k][PROD_WIDTH-1:0];
            low_ff[k] <= {low_ff[k][QUO_BITS-2:0], 1'b0};
            q_ff[k]   <= {q_ff[k][QUO_BITS-2:0], !diff_w[k][PROD_WIDTH]};
         end
      end

      if (cmd.div_done) begin
         for (int k = 0; k < 3; k++) begin
            tan_ff[k]    <= tan_w[k];
            out_id_ff[k] <= idx_ff[k];
         end
         out_degen_ff <= degen_ff;
      end
   end

   always_comb begin
      case (cmd.emit_idx)
         CORNER_FIRST:  out_vertex_id = ID_WIDTH'(out_id_ff[0]);
         CORNER_SECOND: out_vertex_id = ID_WIDTH'(out_id_ff[1]);
         default:       out_vertex_id = ID_WIDTH'(out_id_ff[2]);
      endcase
      tangent_x    = tan_ff[0];
      tangent_y    = tan_ff[1];
      tangent_z    = tan_ff[2];
      degenerate   = out_degen_ff;
      last_of_face = (cmd.emit_idx == CORNER_LAST);
   end

endmodule

// File: hw/rtl/triangle_tangent_from_uv_top.sv
// Top level of the per-triangle tangent block: channel ports, sequencer and
// datapath. Uses tgu_pkg, tgu_req_if/tgu_rsp_if, tgu_ctrl, tgu_datapath.
//
// Usage:
//  - req_if carries triangle corners, three per face, in order. The first two
//    corners are only captured; each is taken while the block is idle or emitting.
//  - The third corner starts the face computation: 8 multiplies on one shared
//    32x32 multiplier, a setup step, a 31-step radix-2 divide run on three
//    lanes in parallel, then a final step to latch the results.
//  - rsp_if then offers three items, one per corner in arrival order, all
//    with the same tangent; last_of_face marks the third. Zero UV determinant
//    gives a zero tangent with degenerate set.
//  - The 31-step divide loop dominates the time spent on a face.
//  - Corners one and two of the next face are accepted while results drain.
//    The third corner waits until all three results of the prior face are
//    taken. A stalled result holds its payload.
//  - Synchronous reset returns to the first corner of a face with no result
//    pending; captured corner data is not cleared.
`timescale 1ns / 1ps

module triangle_tangent_from_uv_top
   import tgu_pkg::*;
#(
   parameter int INDEX_BITS = DEF_INDEX_BITS,   // vertex index bits kept
   parameter int FRAC_BITS  = DEF_FRAC_BITS     // fraction bits of the fixed-point format
) (
   input  logic      clock,
   input  logic      reset,
   tgu_req_if.sink   req_if,
   tgu_rsp_if.source rsp_if
);

   tgu_cmd_type cmd;

   tgu_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .cmd       (cmd)
   );

   tgu_datapath #(
      .INDEX_BITS (INDEX_BITS),
      .FRAC_BITS  (FRAC_BITS)
   ) u_datapath (
      .clock         (clock),
      .cmd           (cmd),
      .vertex_id     (req_if.vertex_id),
      .pos_x         (req_if.pos_x),
      .pos_y         (req_if.pos_y),
      .pos_z         (req_if.pos_z),
      .tex_u         (req_if.tex_u),
      .tex_v         (req_if.tex_v),
      .out_vertex_id (rsp_if.out_vertex_id),
      .tangent_x     (rsp_if.tangent_x),
      .tangent_y     (rsp_if.tangent_y),
      .tangent_z     (rsp_if.tangent_z),
      .degenerate    (rsp_if.degenerate),
      .last_of_face  (rsp_if.last_of_face)
   );

endmodule
